// ----- hw/rtl/ftws_pkg.sv -----
// Shared types and constants of the frame time window statistics block.
// Used by every module in hw/rtl; depends on nothing else.
package ftws_pkg;

   // Field widths of the frame words.
   localparam int TIME_W     = 20;
   localparam int COUNT_W    = 7;
   localparam int CLASS_W    = 2;
   localparam int FRAME_NR_W = 32;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 112;

   // Default window depth of the top level.
   localparam int WINDOW_DEPTH_DEF = 64;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_TARGET = 3'd1,
      CSR_ULTRA  = 3'd2,
      CSR_HIGH   = 3'd3,
      CSR_MEDIUM = 3'd4
   } csr_index_type;

   // Register reset values.
   localparam logic [TIME_W-1:0] TARGET_RST = 20'd16667;
   localparam logic [TIME_W-1:0] ULTRA_RST  = 20'd16667;
   localparam logic [TIME_W-1:0] HIGH_RST   = 20'd33333;
   localparam logic [TIME_W-1:0] MEDIUM_RST = 20'd50000;

   // Performance classes of the newest frame.
   typedef enum logic [CLASS_W-1:0] {
      CLASS_LOW    = 2'd0,
      CLASS_MEDIUM = 2'd1,
      CLASS_HIGH   = 2'd2,
      CLASS_ULTRA  = 2'd3
   } perf_class_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MULT,
      ST_DONE
   } state_type;

   // Status handed from the divider to the sequencer.
   typedef struct packed {
      logic busy;
   } div_status_type;

endpackage

// ----- hw/rtl/frame_time_window_stats_core.sv -----
// Frame time window statistics, top level: configuration registers, sequencer and scanner.
// Depends on ftws_pkg, ftws_chain (with ftws_cell) and ftws_divider.
//
// Each request word carries one frame time in microseconds. A zero time, or any word while
// enable is 0, is dropped with no response. Any other frame enters a chain of WINDOW_DEPTH
// cells holding the newest frames; the chain is then rotated once around, one cell per
// cycle, while a scanner at its tail collects min, max and the slow count and a bit-serial
// divider forms the mean. The response waits for both the chain rotation and the divider;
// the rotation takes longer unless the window is very short. A new request is taken only
// while the sequencer is idle, so a frame is not taken before the last one is through;
// a finished response waits in its own register, so the next frame may be taken before it
// is read. The user must write configuration through the csr port only while no frame is
// in flight; the block itself does not enforce this.
module frame_time_window_stats_core
   import ftws_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request: [19:0] frame_time_us, [23:20] zero.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // Response: [6:0] frames_held, [26:7] mean_time_us, [46:27] min_time_us,
   // [66:47] max_time_us, [73:67] slow_frames, [75:74] perf_class, [76] target_met,
   // [77] below_rate, [78] has_headroom, [79] spike_seen, [111:80] frame_number.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // Configuration writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int KW    = $clog2(WINDOW_DEPTH);
   localparam int SUM_W = TIME_W + CNT_W;

   // Configuration registers.
   logic              enable_ff;
   logic [TIME_W-1:0] target_ff;
   logic [TIME_W-1:0] ultra_ff;
   logic [TIME_W-1:0] high_ff;
   logic [TIME_W-1:0] medium_ff;

   // Window state.
   logic [CNT_W-1:0]  fill_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [31:0]       count_ff;

   // Per-frame results.
   logic [31:0]       frame_nr_ff;
   perf_class_type    class_ff;
   perf_class_type    class_in;
   logic              met_ff;
   logic              below_ff;
   logic              headroom_ff;

   // Scanner.
   logic [KW-1:0]     k_ff;
   logic              scan_done_ff;
   logic [TIME_W-1:0] min_ff;
   logic [TIME_W-1:0] max_ff;
   logic [CNT_W-1:0]  slow_ff;
   logic [CNT_W:0]    held_pos;
   logic              held;
   logic [SUM_W-1:0]  product_ff;

   // Sequencer.
   state_type         state_ff;
   state_type         state_in;
   logic              accept;
   logic              take_item;
   logic              rotate;
   logic              div_start;
   logic              finish;

   // Response register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Datapath links.
   logic [TIME_W-1:0]    frame_time;
   logic [TIME_W-1:0]    tail;
   logic [TIME_W-1:0]    head;
   logic [SUM_W-1:0]     quotient;
   div_status_type       div_status;
   logic [23:0]          time_x9;
   logic [23:0]          target_x10;
   logic [23:0]          time_x4;
   logic [23:0]          target_x5;
   logic [23:0]          time_x6;
   logic [21:0]          slow_lhs;
   logic [21:0]          slow_rhs;
   logic [CNT_W+6:0]     fill_wide;
   logic [CNT_W+6:0]     slow_wide;

   assign frame_time = req_tdata[TIME_W-1:0];
   assign accept     = req_tvalid && req_tready;
   assign take_item  = accept && enable_ff && (frame_time != '0);
   assign csr_ready  = 1'b1;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         target_ff <= TARGET_RST;
         ultra_ff  <= ULTRA_RST;
         high_ff   <= HIGH_RST;
         medium_ff <= MEDIUM_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE: enable_ff <= csr_data[0];
            CSR_TARGET: target_ff <= csr_data;
            CSR_ULTRA:  ultra_ff  <= csr_data;
            CSR_HIGH:   high_ff   <= csr_data;
            CSR_MEDIUM: medium_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Rate tests of the incoming frame as integer products by small constants, and its class.
   always_comb begin
      time_x9    = 24'(frame_time) * 24'd9;
      target_x10 = 24'(target_ff) * 24'd10;
      time_x4    = 24'(frame_time) * 24'd4;
      target_x5  = 24'(target_ff) * 24'd5;
      time_x6    = 24'(frame_time) * 24'd6;
      if (frame_time <= ultra_ff) begin
         class_in = CLASS_ULTRA;
      end else if (frame_time <= high_ff) begin
         class_in = CLASS_HIGH;
      end else if (frame_time <= medium_ff) begin
         class_in = CLASS_MEDIUM;
      end else begin
         class_in = CLASS_LOW;
      end
   end

   // New window sum: the oldest frame at the chain tail drops out once the window is full.
   always_comb begin
      if (fill_ff == CNT_W'(WINDOW_DEPTH)) begin
         sum_in = sum_ff - SUM_W'(tail) + SUM_W'(frame_time);
      end else begin
         sum_in = sum_ff + SUM_W'(frame_time);
      end
   end

   // The chain shifts the new frame in when it is taken and rotates during the scan.
   assign rotate = (state_ff == ST_SCAN) && !scan_done_ff;
   assign head   = rotate ? tail : frame_time;

   ftws_chain #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_chain (
      .clock    (clock),
      .shift_en (take_item || rotate),
      .head_in  (head),
      .tail_out (tail)
   );

   assign div_start = rotate && (k_ff == '0);

   ftws_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   // Rotation step k shows cell WINDOW_DEPTH-1-k at the tail; it is held when that cell
   // index is below the fill count.
   assign held_pos = {{(CNT_W + 1 - KW){1'b0}}, k_ff} + {1'b0, fill_ff};
   assign held     = held_pos >= (CNT_W + 1)'(WINDOW_DEPTH);
   assign slow_lhs = {1'b0, tail, 1'b0};
   assign slow_rhs = 22'(target_ff) * 22'd3;

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and handshake.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      finish     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (take_item) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done_ff && !div_status.busy) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Window control state and frame counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         scan_done_ff <= 1'b0;
      end else if (take_item) begin
         if (fill_ff != CNT_W'(WINDOW_DEPTH)) begin
            fill_ff <= fill_ff + 1'b1;
         end
         sum_ff       <= sum_in;
         count_ff     <= count_ff + 1'b1;
         k_ff         <= '0;
         scan_done_ff <= 1'b0;
      end else if (rotate) begin
         k_ff <= k_ff + 1'b1;
         if (k_ff == KW'(WINDOW_DEPTH - 1)) begin
            scan_done_ff <= 1'b1;
         end
      end
   end

   // Per-frame results and scanner accumulators.
   always_ff @(posedge clock) begin
      if (take_item) begin
         frame_nr_ff <= count_ff;
         class_ff    <= class_in;
         met_ff      <= time_x9 <= target_x10;
         below_ff    <= time_x4 > target_x5;
         headroom_ff <= time_x6 < target_x5;
         min_ff      <= '1;
         max_ff      <= '0;
         slow_ff     <= '0;
      end else if (rotate && held) begin
         if (tail < min_ff) begin
            min_ff <= tail;
         end
         if (tail > max_ff) begin
            max_ff <= tail;
         end
         if (slow_lhs > slow_rhs) begin
            slow_ff <= slow_ff + 1'b1;
         end
      end
      if (state_ff == ST_MULT) begin
         product_ff <= SUM_W'(max_ff) * SUM_W'(fill_ff);
      end
   end

   // Response register.
   assign fill_wide = {7'd0, fill_ff};
   assign slow_wide = {7'd0, slow_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= {frame_nr_ff,
                         {1'b0, product_ff} > {sum_ff, 1'b0},
                         headroom_ff,
                         below_ff,
                         met_ff,
                         class_ff,
                         slow_wide[6:0],
                         max_ff,
                         min_ff,
                         quotient[TIME_W-1:0],
                         fill_wide[6:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/ftws_cell.sv -----
// One cell of the window chain: holds one frame time and takes its neighbor's value on a shift.
// Depends on ftws_pkg.
module ftws_cell
   import ftws_pkg::*;
(
   input  logic              clock,
   input  logic              shift_en,
   input  logic [TIME_W-1:0] data_in,
   output logic [TIME_W-1:0] data_out
);

   logic [TIME_W-1:0] data_ff;

   // Payload register, no reset needed; cells are only read once written.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

// ----- hw/rtl/ftws_chain.sv -----
// Row of window cells. Cell 0 holds the newest frame; the last cell feeds the scanner.
// Depends on ftws_pkg and ftws_cell.
module ftws_chain
   import ftws_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              shift_en,
   input  logic [TIME_W-1:0] head_in,
   output logic [TIME_W-1:0] tail_out
);

   logic [TIME_W-1:0] link [WINDOW_DEPTH+1];

   assign link[0] = head_in;

   // Each cell takes the value of the cell before it.
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      ftws_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .data_in  (link[i]),
         .data_out (link[i+1])
      );
   end

   assign tail_out = link[WINDOW_DEPTH];

endmodule

// ----- hw/rtl/ftws_divider.sv -----
// Restoring divider, one quotient bit per cycle, used for the window mean.
// Depends on ftws_pkg.
module ftws_divider
   import ftws_pkg::*;
#(
   parameter int DIVIDEND_W = 26,
   parameter int DIVISOR_W  = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output div_status_type        status,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  divisor_ff;

   logic [DIVISOR_W:0]    trial;
   logic                  fits;
   logic [DIVISOR_W:0]    diff;

   // Shift in the next dividend bit and try to subtract the divisor.
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, divisor_ff};
      diff  = trial - {1'b0, divisor_ff};
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIVIDEND_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Remainder and quotient registers; the quotient bits replace the dividend from the bottom.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quo_ff     <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign status.busy = busy_ff;
   assign quotient    = quo_ff;

endmodule

// ----- tb/tb_frame_time_window_stats_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of frame_time_window_stats_core: random and directed frame words
// are checked against a window statistics predictor. Depends on ftws_pkg and the core RTL.
module tb_frame_time_window_stats_core;
   import ftws_pkg::*;

   localparam int DEPTH         = WINDOW_DEPTH_DEF;
   localparam int SETTLE_CYCLES = 80;
   localparam int IDLE_PCT      = 22;
   localparam int STALL_LIMIT   = 5000;
   localparam int CALM_FROM     = 700;
   localparam int CALM_TO       = 1000;
   localparam int HOLD_AT       = 250;
   localparam int HOLD_LEN      = 500;
   localparam int PAUSE_AT      = 1200;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // One response word, packed in the same order as rsp_tdata (top field first).
   typedef struct packed {
      logic [FRAME_NR_W-1:0] frame_number;
      logic                  spike_seen;
      logic                  has_headroom;
      logic                  below_rate;
      logic                  target_met;
      perf_class_type        perf_class;
      logic [COUNT_W-1:0]    slow_frames;
      logic [TIME_W-1:0]     max_time_us;
      logic [TIME_W-1:0]     min_time_us;
      logic [TIME_W-1:0]     mean_time_us;
      logic [COUNT_W-1:0]    frames_held;
   } frame_stats_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_ENABLE;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   frame_time_window_stats_core #(
      .WINDOW_DEPTH(DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Register copies as the block should hold them.
   logic              cfg_enable = 1'b1;
   logic [TIME_W-1:0] cfg_target = TARGET_RST;
   logic [TIME_W-1:0] cfg_ultra  = ULTRA_RST;
   logic [TIME_W-1:0] cfg_high   = HIGH_RST;
   logic [TIME_W-1:0] cfg_medium = MEDIUM_RST;

   // Window state of the predictor.
   logic [TIME_W-1:0]     win_mem [DEPTH];
   int unsigned           win_slot  = 0;
   int unsigned           win_fill  = 0;
   logic [25:0]           win_sum   = '0;
   logic [FRAME_NR_W-1:0] frame_cnt = '0;

   logic [TIME_W-1:0] frame_backlog [$];
   frame_stats_type   pending_stats [$];
   int unsigned       frames_queued = 0;
   int unsigned       frames_sent   = 0;
   int unsigned       stats_checked = 0;
   int unsigned       settings_run  = 1;
   int unsigned       errors        = 0;
   int unsigned       hold_left     = 0;
   bit                pause_done    = 1'b0;

   // Adds one nonzero frame to the window while enabled and queues the statistics the block should report.
   task automatic update_window_stats(input logic [TIME_W-1:0] t);
      frame_stats_type s;
      logic [TIME_W-1:0] lo, hi, v;
      int unsigned slow;
      logic [63:0] t64, tgt64;
      if (!cfg_enable || t == '0) return;
      if (win_fill == DEPTH) win_sum = win_sum - win_mem[win_slot];
      else win_fill++;
      win_mem[win_slot] = t;
      win_sum = win_sum + t;
      win_slot = (win_slot + 1) % DEPTH;

      t64   = 64'(t);
      tgt64 = 64'(cfg_target);
      lo    = win_mem[0];
      hi    = win_mem[0];
      slow  = 0;
      for (int i = 0; i < win_fill; i++) begin
         v = win_mem[i];
         if (v < lo) lo = v;
         if (v > hi) hi = v;
         if (2 * 64'(v) > 3 * tgt64) slow++;
      end

      s.frames_held  = COUNT_W'(win_fill);
      s.mean_time_us = TIME_W'(win_sum / win_fill);
      s.min_time_us  = lo;
      s.max_time_us  = hi;
      s.slow_frames  = COUNT_W'(slow);
      // Class tests run in the listed order even when the thresholds are not sorted.
      if (t <= cfg_ultra) s.perf_class = CLASS_ULTRA;
      else if (t <= cfg_high) s.perf_class = CLASS_HIGH;
      else if (t <= cfg_medium) s.perf_class = CLASS_MEDIUM;
      else s.perf_class = CLASS_LOW;
      s.target_met   = (9 * t64 <= 10 * tgt64);
      s.below_rate   = (4 * t64 > 5 * tgt64);
      s.has_headroom = (6 * t64 < 5 * tgt64);
      s.spike_seen   = (64'(hi) * win_fill > 2 * 64'(win_sum));
      s.frame_number = frame_cnt;
      frame_cnt = frame_cnt + 1'b1;
      pending_stats.push_back(s);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic push_frame(input logic [TIME_W-1:0] t);
      frame_backlog.push_back(t);
      frames_queued++;
   endtask

   // Random frames: mostly around the target and thresholds, some full range, a few zeros.
   task automatic queue_random_frames(input int n);
      logic [63:0] span;
      int unsigned roll;
      span = 64'(cfg_target) * 2 + 2;
      if (64'(cfg_medium) + 2 > span) span = 64'(cfg_medium) + (64'(cfg_medium) >> 2) + 2;
      if (span > TIME_MAX) span = TIME_MAX;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(99);
         if (roll < 4) push_frame('0);
         else if (roll < 8) push_frame(($urandom_range(1) != 0) ? TIME_MAX : TIME_W'(1));
         else if (roll < 35) push_frame(TIME_W'($urandom_range(1, TIME_MAX)));
         else push_frame(TIME_W'($urandom_range(1, int'(span))));
      end
   endtask

   // Writes all registers back to back; the block is idle whenever this runs.
   task automatic program_csrs(input logic en, input logic [TIME_W-1:0] tgt,
                               input logic [TIME_W-1:0] ul, input logic [TIME_W-1:0] hi,
                               input logic [TIME_W-1:0] md);
      csr_index_type    regs [5];
      logic [TIME_W-1:0] vals [5];
      regs = '{CSR_ENABLE, CSR_TARGET, CSR_ULTRA, CSR_HIGH, CSR_MEDIUM};
      vals = '{TIME_W'(en), tgt, ul, hi, md};
      csr_valid <= 1'b1;
      foreach (regs[k]) begin
         csr_index <= regs[k];
         csr_data  <= vals[k];
         do @(posedge clock); while (!csr_ready);
         case (regs[k])
            CSR_ENABLE: cfg_enable = vals[k][0];
            CSR_TARGET: cfg_target = vals[k];
            CSR_ULTRA:  cfg_ultra  = vals[k];
            CSR_HIGH:   cfg_high   = vals[k];
            CSR_MEDIUM: cfg_medium = vals[k];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   // Waits until every queued frame is taken and every expected word has come.
   task automatic wait_drain();
      do @(posedge clock); while (frames_sent != frames_queued || pending_stats.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: presents frame words from the backlog and predicts each accepted one.
   always @(posedge clock) begin : frame_driver
      bit idle_now;
      bit calm;
      bit pausing;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            update_window_stats(req_tdata[TIME_W-1:0]);
            frames_sent++;
         end
         if (!req_tvalid || req_tready) begin
            calm    = (frames_sent >= CALM_FROM && frames_sent < CALM_TO);
            idle_now = !calm && ($urandom_range(99) < IDLE_PCT);
            // Once, the sender stops until the block has handed back everything.
            pausing = 1'b0;
            if (frames_sent == PAUSE_AT && !pause_done) begin
               if (pending_stats.size() == 0) pause_done = 1'b1;
               else pausing = 1'b1;
            end
            if (frame_backlog.size() != 0 && !idle_now && !pausing) begin
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'(frame_backlog.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response word against the oldest prediction.
   always @(posedge clock) begin : stats_monitor
      frame_stats_type got;
      frame_stats_type want;
      bit calm;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_stats.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = pending_stats.pop_front();
               check_field("frames_held", want.frames_held, got.frames_held);
               check_field("mean_time_us", want.mean_time_us, got.mean_time_us);
               check_field("min_time_us", want.min_time_us, got.min_time_us);
               check_field("max_time_us", want.max_time_us, got.max_time_us);
               check_field("slow_frames", want.slow_frames, got.slow_frames);
               check_field("perf_class", want.perf_class, got.perf_class);
               check_field("target_met", want.target_met, got.target_met);
               check_field("below_rate", want.below_rate, got.below_rate);
               check_field("has_headroom", want.has_headroom, got.has_headroom);
               check_field("spike_seen", want.spike_seen, got.spike_seen);
               check_field("frame_number", want.frame_number, got.frame_number);
            end
            stats_checked++;
            // A long hold-off lets the block back up into its request side.
            if (stats_checked == HOLD_AT) hold_left = HOLD_LEN;
         end
         calm = (stats_checked >= CALM_FROM && stats_checked < CALM_TO);
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: too many cycles with no word moving on any channel ends the run.
   always @(posedge clock) begin : stall_watchdog
      int unsigned quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, quiet);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Stimulus sequence: directed frames at reset values, then register phases.
   initial begin : stimulus
      logic [TIME_W-1:0] tg, ul, hi, md;
      int edges [4];
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Field extremes, ignored zero, class boundaries and the rate test edges.
      push_frame(TIME_W'(1));
      push_frame(TIME_MAX);
      push_frame('0);
      push_frame(ULTRA_RST);
      push_frame(ULTRA_RST + 1'b1);
      push_frame(HIGH_RST);
      push_frame(HIGH_RST + 1'b1);
      push_frame(MEDIUM_RST);
      push_frame(MEDIUM_RST + 1'b1);
      edges = '{(10 * TARGET_RST) / 9, (5 * TARGET_RST) / 4, (5 * TARGET_RST) / 6,
                (3 * TARGET_RST) / 2};
      foreach (edges[k]) begin
         push_frame(TIME_W'(edges[k]));
         push_frame(TIME_W'(edges[k] + 1));
      end
      push_frame(20'h55555);
      push_frame(20'hAAAAA);
      wait_drain();

      program_csrs(1'b1, TARGET_RST, 20'd8333, TARGET_RST, HIGH_RST);
      queue_random_frames(500);
      wait_drain();

      // Smallest and largest register values.
      program_csrs(1'b1, TIME_W'(1), TIME_W'(1), TIME_W'(1), TIME_W'(1));
      queue_random_frames(150);
      wait_drain();
      program_csrs(1'b1, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
      queue_random_frames(150);
      wait_drain();

      // Disabled: every frame is dropped and the window is kept for later.
      program_csrs(1'b0, TARGET_RST, ULTRA_RST, HIGH_RST, MEDIUM_RST);
      queue_random_frames(60);
      wait_drain();

      // Registers at zero, then thresholds in reverse order.
      program_csrs(1'b1, '0, '0, '0, '0);
      queue_random_frames(100);
      wait_drain();
      program_csrs(1'b1, 20'd33333, 20'd50000, 20'd20000, 20'd10000);
      queue_random_frames(300);
      wait_drain();

      // Random register settings with ordered thresholds.
      for (int p = 0; p < 3; p++) begin
         tg = TIME_W'($urandom_range(1, 150000));
         ul = TIME_W'($urandom_range(1, 100000));
         hi = ul + TIME_W'($urandom_range(0, 100000));
         md = hi + TIME_W'($urandom_range(0, 100000));
         program_csrs(1'b1, tg, ul, hi, md);
         queue_random_frames(200);
         wait_drain();
      end

      $display("Covered %0d frame words and %0d checked statistics words under %0d settings.",
               frames_sent, stats_checked, settings_run);
      $display("Included a long response hold-off, a sender pause and an enable-off phase.");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/ftws_pkg.sv
hw/rtl/ftws_cell.sv
hw/rtl/ftws_chain.sv
hw/rtl/ftws_divider.sv
hw/rtl/frame_time_window_stats_core.sv
tb/tb_frame_time_window_stats_core.sv
